// ----- rtl/triangle_tangent_bitangent_defines.svh -----
// ----------------------------------------------------------------------------
// triangle_tangent_bitangent_defines.svh
// Assertion macros for the port-level checker file.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_TANGENT_BITANGENT_DEFINES_SVH
`define TRIANGLE_TANGENT_BITANGENT_DEFINES_SVH

// clocked assertion, off while reset is high
`define TTB_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// clocked assertion that also runs through reset
`define TTB_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ----- rtl/ttb_pkg.sv -----
// ----------------------------------------------------------------------------
// ttb_pkg
// Types and widths for the triangle tangent/bitangent block.
// ----------------------------------------------------------------------------
package ttb_pkg;

  localparam int POS_W   = 32;
  localparam int UV_W    = 16;
  localparam int UV_FRAC = 12;
  localparam int Q_W     = 32;
  localparam int E_W     = POS_W + 1;          // edge delta
  localparam int D_W     = UV_W + 1;           // uv delta
  localparam int PROD_W  = E_W + D_W;          // one product
  localparam int NUM_W   = PROD_W + 1;         // difference of products
  localparam int DET_W   = 2 * D_W + 1;        // determinant
  localparam int NPAIR   = 7;                  // det + 6 numerators

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [UV_W-1:0]  tex_u;
    logic signed [UV_W-1:0]  tex_v;
  } ttb_in_t;

  typedef struct packed {
    logic signed [Q_W-1:0] tangent_x;
    logic signed [Q_W-1:0] tangent_y;
    logic signed [Q_W-1:0] tangent_z;
    logic signed [Q_W-1:0] bitangent_x;
    logic signed [Q_W-1:0] bitangent_y;
    logic signed [Q_W-1:0] bitangent_z;
    logic                  degenerate;
  } ttb_out_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [DET_W-1:0] det;
  } ttb_div_req_t;

endpackage

// ----- rtl/ttb_mul.sv -----
// ----------------------------------------------------------------------------
// ttb_mul
// Shared signed multiplier, uv delta by edge delta or uv delta, registered product.
// ----------------------------------------------------------------------------
module ttb_mul
  import ttb_pkg::*;
(
  input  logic                     clk,
  input  logic signed [D_W-1:0]    a,
  input  logic signed [E_W-1:0]    b,
  output logic signed [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

// ----- rtl/ttb_div.sv -----
// ----------------------------------------------------------------------------
// ttb_div
// Restoring divider: (num << UV_FRAC) / det, truncated, saturated to Q_W bits.
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module ttb_div
  import ttb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  ttb_div_req_t         req,
  output logic                 done,
  output logic signed [Q_W-1:0] q
);

  localparam int R_W  = DET_W + 1;
  localparam int HI_W = NUM_W + UV_FRAC - Q_W;
  localparam int C_W  = $clog2(Q_W + 1);

  logic [NUM_W-1:0] un;
  logic [DET_W-1:0] ud_in;
  logic [HI_W-1:0]  hi;
  logic             ovf_in;

  logic             busy;
  logic [C_W-1:0]   cnt;
  logic [R_W-1:0]   rem;
  logic [Q_W-1:0]   low;
  logic [Q_W-1:0]   quo;
  logic [DET_W-1:0] ud;
  logic             neg;
  logic             ovf;
  logic [R_W-1:0]   rem2;
  logic [R_W-1:0]   diff;
  logic [Q_W-1:0]   quo_next;

  always_comb begin
    un     = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
    ud_in  = req.det[DET_W-1] ? DET_W'(-req.det) : DET_W'(req.det);
    hi     = HI_W'({un, {UV_FRAC{1'b0}}} >> Q_W);
    ovf_in = R_W'(hi) >= R_W'(ud_in);
    rem2   = {rem[R_W-2:0], low[Q_W-1]};
    diff   = rem2 - R_W'(ud);
    quo_next = {quo[Q_W-2:0], ~diff[R_W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= C_W'(Q_W);
        rem  <= R_W'(hi);
        low  <= Q_W'({un, {UV_FRAC{1'b0}}});
        ud   <= ud_in;
        neg  <= req.num[NUM_W-1] ^ req.det[DET_W-1];
        ovf  <= ovf_in;
        quo  <= '0;
      end else if (busy) begin
        if (cnt != '0) begin
          rem <= diff[R_W-1] ? rem2 : diff;
          low <= {low[Q_W-2:0], 1'b0};
          quo <= quo_next;
          cnt <= cnt - 1'b1;
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
          if (neg) begin
            q <= (ovf || quo[Q_W-1]) ? {1'b1, {(Q_W-1){1'b0}}} : Q_W'(-quo);
          end else begin
            q <= (ovf || quo[Q_W-1]) ? {1'b0, {(Q_W-1){1'b1}}} : quo;
          end
        end
      end
    end
  end

endmodule

// ----- rtl/triangle_tangent_bitangent.sv -----
// ----------------------------------------------------------------------------
// triangle_tangent_bitangent
// Per-triangle tangent and bitangent from positions and texture coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one vertex per request (Q16.16 position, Q4.12 uv), sent
//                 in triangle order. Corners 0 and 1 are held in registers.
//   out channel : one request per third corner while tangent_enable is 1:
//                 tangent, bitangent (Q16.16, saturated) and a degenerate
//                 flag for a zero uv determinant (vectors then zero).
//   cfg channel : writes tangent_enable; always ready.
// Sequence:
//   Corners 0 and 1 are stored as they are taken. The third corner runs 14
//   products through one shared multiplier, then six quotients through one
//   bit-serial divider, then the emit state: in_ready stays low from when
//   the third corner is taken until the result is loaded. A degenerate
//   triangle skips the divider; a disabled one keeps in_ready high.
// Reset clears the corner count, sets tangent_enable and drops out_valid.
// A stalled receiver holds the result; the block takes further vertices
// but waits to load the next result until the held one is taken.
// ----------------------------------------------------------------------------
module triangle_tangent_bitangent
  import ttb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  ttb_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ttb_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_ISSUE, S_MUL_ACC, S_DIV_START, S_DIV_WAIT, S_EMIT
  } state_t;

  state_t state;
  logic   enable;
  logic [1:0] corner_count;

  // corners 0 and 1
  logic signed [POS_W-1:0] held_pos [2][3];
  logic signed [UV_W-1:0]  held_uv  [2][2];

  // deltas of the current triangle
  logic signed [E_W-1:0] e1 [3];
  logic signed [E_W-1:0] e2 [3];
  logic signed [D_W-1:0] d1u, d1v, d2u, d2v;

  // sequencer
  logic [2:0]              idx;
  logic                    term;
  logic signed [PROD_W-1:0] acc;
  logic signed [NUM_W-1:0] num [NPAIR];
  logic signed [Q_W-1:0]   res [6];
  logic                    degen;

  logic signed [D_W-1:0]    mul_a;
  logic signed [E_W-1:0]    mul_b;
  logic signed [PROD_W-1:0] prod;
  ttb_div_req_t             div_req;
  logic                     div_done;
  logic signed [Q_W-1:0]    div_q;
  logic                     in_fire;
  logic [1:0]               comp;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  // operand select for the shared multiplier
  always_comb begin
    comp  = 2'(idx - 3'd1);
    mul_a = d1u;
    mul_b = E_W'(d2v);
    if (idx == 3'd0) begin
      mul_a = term ? d2u : d1u;
      mul_b = term ? E_W'(d1v) : E_W'(d2v);
    end else if (idx <= 3'd3) begin
      mul_a = term ? d1v : d2v;
      mul_b = term ? e2[comp] : e1[comp];
    end else begin
      comp  = 2'(idx - 3'd4);
      mul_a = term ? d2u : d1u;
      mul_b = term ? e1[comp] : e2[comp];
    end
  end

  always_comb begin
    div_req.start = (state == S_DIV_START);
    div_req.num   = num[3'(idx + 3'd1)];
    div_req.det   = DET_W'(num[0]);
  end

  ttb_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  ttb_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .q    (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      enable       <= 1'b1;
      corner_count <= '0;
      out_valid    <= 1'b0;
      idx          <= '0;
      term         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        enable <= cfg_data;
      end
      // the emit state reloads out_valid itself
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (corner_count == 2'd2) begin
              corner_count <= '0;
              e1[0] <= E_W'(held_pos[1][0]) - E_W'(held_pos[0][0]);
              e1[1] <= E_W'(held_pos[1][1]) - E_W'(held_pos[0][1]);
              e1[2] <= E_W'(held_pos[1][2]) - E_W'(held_pos[0][2]);
              e2[0] <= E_W'(in_data.pos_x) - E_W'(held_pos[0][0]);
              e2[1] <= E_W'(in_data.pos_y) - E_W'(held_pos[0][1]);
              e2[2] <= E_W'(in_data.pos_z) - E_W'(held_pos[0][2]);
              d1u   <= D_W'(held_uv[1][0]) - D_W'(held_uv[0][0]);
              d1v   <= D_W'(held_uv[1][1]) - D_W'(held_uv[0][1]);
              d2u   <= D_W'(in_data.tex_u) - D_W'(held_uv[0][0]);
              d2v   <= D_W'(in_data.tex_v) - D_W'(held_uv[0][1]);
              idx   <= '0;
              term  <= 1'b0;
              if (enable) begin
                state <= S_MUL_ISSUE;
              end
            end else begin
              // a count of 3 cannot occur; it would fall here as corner 1
              held_pos[corner_count[0]][0] <= in_data.pos_x;
              held_pos[corner_count[0]][1] <= in_data.pos_y;
              held_pos[corner_count[0]][2] <= in_data.pos_z;
              held_uv[corner_count[0]][0]  <= in_data.tex_u;
              held_uv[corner_count[0]][1]  <= in_data.tex_v;
              corner_count <= corner_count + 2'd1;
            end
          end
        end

        S_MUL_ISSUE: begin
          state <= S_MUL_ACC;
        end

        S_MUL_ACC: begin
          if (!term) begin
            acc   <= prod;
            term  <= 1'b1;
            state <= S_MUL_ISSUE;
          end else begin
            num[idx] <= NUM_W'(acc) - NUM_W'(prod);
            term     <= 1'b0;
            if (idx == 3'(NPAIR - 1)) begin
              idx <= '0;
              if (num[0] == '0) begin
                degen <= 1'b1;
                for (int i = 0; i < 6; i++) begin
                  res[i] <= '0;
                end
                state <= S_EMIT;
              end else begin
                degen <= 1'b0;
                state <= S_DIV_START;
              end
            end else begin
              idx   <= idx + 3'd1;
              state <= S_MUL_ISSUE;
            end
          end
        end

        S_DIV_START: begin
          state <= S_DIV_WAIT;
        end

        S_DIV_WAIT: begin
          if (div_done) begin
            res[idx] <= div_q;
            if (idx == 3'd5) begin
              idx   <= '0;
              state <= S_EMIT;
            end else begin
              idx   <= idx + 3'd1;
              state <= S_DIV_START;
            end
          end
        end

        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid            <= 1'b1;
            out_data.tangent_x   <= res[0];
            out_data.tangent_y   <= res[1];
            out_data.tangent_z   <= res[2];
            out_data.bitangent_x <= res[3];
            out_data.bitangent_y <= res[4];
            out_data.bitangent_z <= res[5];
            out_data.degenerate  <= degen;
            state                <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/ttb_checker.sv -----
// ----------------------------------------------------------------------------
// ttb_checker
// Port-level checks for triangle_tangent_bitangent, bound to the top level.
// ----------------------------------------------------------------------------
`include "triangle_tangent_bitangent_defines.svh"

module ttb_checker
  import ttb_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input ttb_out_t out_data
);

  `TTB_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !out_valid, "out_valid after reset")

  `TTB_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled request changed")

  `TTB_ASSERT(a_degen_zero, clk, rst, out_valid && out_data.degenerate |-> out_data.tangent_x == 0 && out_data.tangent_y == 0 && out_data.tangent_z == 0 && out_data.bitangent_x == 0 && out_data.bitangent_y == 0 && out_data.bitangent_z == 0, "degenerate with nonzero vector")

  `TTB_ASSERT(a_busy_after_out, clk, rst, out_valid && !$past(out_valid) |-> $past(!in_ready), "result without preceding work")

endmodule

bind triangle_tangent_bitangent ttb_checker u_ttb_checker (.*);

// ----- tb/ttb_checker.sv -----
// ----------------------------------------------------------------------------
// ttb_scoreboard
// Watches the vertex, result and register channels of the tangent block. It
// keeps its own copy of the held corners and of the enable bit, works out the
// result that each third corner should give, and compares it field by field
// with the result requests that the receiver accepts.
// ----------------------------------------------------------------------------
module ttb_scoreboard
  import ttb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_ready,
  input  ttb_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  ttb_out_t out_data,
  input  logic     cfg_valid,
  input  logic     cfg_ready,
  input  logic     cfg_data,
  output int       mismatches,
  output int       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [POS_W-1:0] held_pos[2][3];
  logic signed [UV_W-1:0]  held_uv[2][2];
  int unsigned             corners;
  bit                      tangents_on;
  ttb_out_t                result_q[$];
  int                      errs;

  // (num << 12) / det, truncated toward zero, clamped to 32 bits
  function automatic logic [Q_W-1:0] clamp_quotient(longint num, longint det);
    bit                neg;
    longint unsigned   un, ud, q;
    neg = (num < 0) != (det < 0);
    un  = (num < 0) ? longint'(-num) : num;
    ud  = (det < 0) ? longint'(-det) : det;
    q   = (un << UV_FRAC) / ud;
    if (neg) begin
      if (q >= 64'h8000_0000) return 32'h8000_0000;
      return 32'(-q);
    end
    if (q > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return 32'(q);
  endfunction

  // advance the corner state by one vertex; returns 1 when a result is due
  function automatic bit next_vertex(input ttb_in_t v, output ttb_out_t r);
    longint e1[3], e2[3], cur[3];
    longint d1u, d1v, d2u, d2v, det;
    r = '0;
    cur[0] = v.pos_x;
    cur[1] = v.pos_y;
    cur[2] = v.pos_z;
    if (corners >= 3) corners = 0;
    if (corners < 2) begin
      for (int a = 0; a < 3; a++) held_pos[corners][a] = cur[a];
      held_uv[corners][0] = v.tex_u;
      held_uv[corners][1] = v.tex_v;
      corners++;
      return 0;
    end
    corners = 0;
    if (!tangents_on) return 0;
    for (int a = 0; a < 3; a++) begin
      e1[a] = longint'(held_pos[1][a]) - longint'(held_pos[0][a]);
      e2[a] = cur[a] - longint'(held_pos[0][a]);
    end
    d1u = longint'(held_uv[1][0]) - longint'(held_uv[0][0]);
    d1v = longint'(held_uv[1][1]) - longint'(held_uv[0][1]);
    d2u = longint'(v.tex_u) - longint'(held_uv[0][0]);
    d2v = longint'(v.tex_v) - longint'(held_uv[0][1]);
    det = d1u * d2v - d2u * d1v;
    if (det == 0) begin
      r.degenerate = 1'b1;
      return 1;
    end
    r.tangent_x   = clamp_quotient(d2v * e1[0] - d1v * e2[0], det);
    r.tangent_y   = clamp_quotient(d2v * e1[1] - d1v * e2[1], det);
    r.tangent_z   = clamp_quotient(d2v * e1[2] - d1v * e2[2], det);
    r.bitangent_x = clamp_quotient(d1u * e2[0] - d2u * e1[0], det);
    r.bitangent_y = clamp_quotient(d1u * e2[1] - d2u * e1[1], det);
    r.bitangent_z = clamp_quotient(d1u * e2[2] - d2u * e1[2], det);
    return 1;
  endfunction

  function automatic int field_diff(string name, logic [Q_W-1:0] exp_v,
                                    logic [Q_W-1:0] got_v);
    if (exp_v === got_v) return 0;
    $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(got_v));
    return 1;
  endfunction

  always @(posedge clk) begin
    ttb_out_t want;
    ttb_out_t got;
    if (rst) begin
      corners     = 0;
      tangents_on = 1'b1;
      result_q.delete();
      errs        = 0;
    end else begin
      if (cfg_valid && cfg_ready) tangents_on = cfg_data;
      if (in_valid && in_ready) begin
        if (next_vertex(in_data, want)) result_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (result_q.size() == 0) begin
          $error("result request with no triangle outstanding");
          errs++;
        end else begin
          want = result_q.pop_front();
          errs += field_diff("tangent_x", want.tangent_x, got.tangent_x);
          errs += field_diff("tangent_y", want.tangent_y, got.tangent_y);
          errs += field_diff("tangent_z", want.tangent_z, got.tangent_z);
          errs += field_diff("bitangent_x", want.bitangent_x, got.bitangent_x);
          errs += field_diff("bitangent_y", want.bitangent_y, got.bitangent_y);
          errs += field_diff("bitangent_z", want.bitangent_z, got.bitangent_z);
          errs += field_diff("degenerate", 32'(want.degenerate),
                             32'(got.degenerate));
        end
      end
    end
    mismatches <= errs;
    pending    <= result_q.size();
  end

endmodule

// ----- tb/tb_triangle_tangent_bitangent.sv -----
// ----------------------------------------------------------------------------
// tb_triangle_tangent_bitangent
// Drives vertex and register requests into the tangent block, with random
// gaps and receiver stalls, and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------
module tb_triangle_tangent_bitangent;
  import ttb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = 300;   // longer than one full triangle
  localparam int LONG_HOLD   = 800;   // several triangles' worth

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  ttb_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b1;
  ttb_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic     cfg_data = 1'b0;
  int       mismatches;
  int       pending;

  // knobs shared between the stimulus and the receiver
  bit       gaps_on  = 1'b1;
  bit       stall_on = 1'b1;
  bit       hold_req = 1'b0;
  int       sent     = 0;
  int       cycles   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  triangle_tangent_bitangent DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  ttb_scoreboard u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .mismatches(mismatches),
    .pending   (pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("triangle_tangent_bitangent: mismatch");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request so the
  // block ends up holding a result and stalls its vertex input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req   = 1'b0;
        out_ready <= 1'b1;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // One vertex request. valid only drops when a gap follows, so it never
  // falls and rises within one step.
  task automatic send_vertex(input ttb_in_t v);
    int gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= v;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every triangle result is back, then let the block settle
  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_enable(input logic val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic ttb_in_t vtx(input int x, input int y, input int z,
                                  input int u, input int v);
    ttb_in_t t;
    t.pos_x = x;
    t.pos_y = y;
    t.pos_z = z;
    t.tex_u = 16'(u);
    t.tex_v = 16'(v);
    return t;
  endfunction

  // Random vertex. Mostly modest positions and uvs so quotients land in
  // range, some full-range values for saturation and bit coverage.
  function automatic ttb_in_t rand_vertex();
    ttb_in_t t;
    if ($urandom_range(0, 3) == 0) begin
      t.pos_x = $urandom;
      t.pos_y = $urandom;
      t.pos_z = $urandom;
    end else begin
      t.pos_x = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      t.pos_y = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      t.pos_z = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    end
    if ($urandom_range(0, 2) == 0) begin
      t.tex_u = 16'($urandom);
      t.tex_v = 16'($urandom);
    end else begin
      t.tex_u = 16'($urandom_range(0, 8192)) - 16'd4096;
      t.tex_v = 16'($urandom_range(0, 8192)) - 16'd4096;
    end
    return t;
  endfunction

  // A triangle with random content; now and then a zero determinant, either
  // all corners sharing one uv or the third uv on the line of the first two.
  task automatic send_triangle();
    ttb_in_t a, b, c;
    int      kind;
    a = rand_vertex();
    b = rand_vertex();
    c = rand_vertex();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      b.tex_u = a.tex_u;  b.tex_v = a.tex_v;
      c.tex_u = a.tex_u;  c.tex_v = a.tex_v;
    end else if (kind == 1) begin
      a.tex_u = 16'($urandom_range(0, 512));
      a.tex_v = 16'($urandom_range(0, 512));
      b.tex_u = a.tex_u + 16'd100;  b.tex_v = a.tex_v + 16'd37;
      c.tex_u = a.tex_u + 16'd200;  c.tex_v = a.tex_v + 16'd74;
    end
    send_vertex(a);
    send_vertex(b);
    send_vertex(c);
  endtask

  task automatic random_phase(input int count);
    int target;
    target = sent + count;
    while (sent < target) send_triangle();
    drop_valid();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed triangles ---
    // unit square corner: tangent +x, bitangent +y
    send_vertex(vtx(0, 0, 0, 0, 0));
    send_vertex(vtx(32'h1_0000, 0, 0, 4096, 0));
    send_vertex(vtx(0, 32'h1_0000, 0, 0, 4096));
    // all corners on one uv: degenerate
    send_vertex(vtx(5, 6, 7, 123, -77));
    send_vertex(vtx(-5, 600, 17, 123, -77));
    send_vertex(vtx(99, -6, 70, 123, -77));
    // position and uv extremes
    send_vertex(vtx(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, -32768, 32767));
    send_vertex(vtx(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32767, -32768));
    send_vertex(vtx(0, 0, 0, -32768, -32768));
    // det of one with huge edges: clamps high and low
    send_vertex(vtx(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0));
    send_vertex(vtx(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0));
    send_vertex(vtx(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1));
    // mirrored: clamps low
    send_vertex(vtx(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
    send_vertex(vtx(32'h8000_0000, 32'h8000_0000, 0, 1, 0));
    send_vertex(vtx(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 1));
    // collinear uv: degenerate with nonzero deltas
    send_vertex(vtx(1, 2, 3, 0, 0));
    send_vertex(vtx(4, 5, 6, 300, 500));
    send_vertex(vtx(7, 8, 9, 600, 1000));
    // negative det, small values
    send_vertex(vtx(-32'sh3_0000, 32'h2_8000, 12, -4096, 4096));
    send_vertex(vtx(32'h1_0000, -32'sh1_0000, 300, 4096, 4096));
    send_vertex(vtx(7, 32'h4_0000, -9, 4096, -4096));
    drop_valid();

    // --- random, enabled; receiver holds off while vertices keep coming ---
    random_phase(150);
    hold_req = 1'b1;
    random_phase(450);

    // sender pauses until every result is back, then disable mid-stream
    write_enable(1'b0);
    send_vertex(rand_vertex());
    random_phase(300);
    drop_valid();

    // re-enable with one corner held, so the write lands mid-triangle
    write_enable(1'b1);
    random_phase(500);

    // --- last stretch: no gaps, no stalls ---
    wait_drained();
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    random_phase(550);

    wait_drained();
    if (mismatches == 0) begin
      $display("triangle_tangent_bitangent: match");
    end else begin
      $display("triangle_tangent_bitangent: mismatch");
    end
    $finish;
  end

endmodule
